[rtl/core/spmr_pkg.sv]
package spmr_pkg;

    localparam int MAX_ROWS    = 8;
    localparam int MAX_COLS    = 8;
    localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int POS_W       = $clog2(MAX_ROWS > MAX_COLS ? MAX_ROWS : MAX_COLS);
    localparam int DIM_W       = 4;
    localparam int DATA_W      = 32;

    localparam logic REG_ROW_COUNT    = 1'b0;
    localparam logic REG_COLUMN_COUNT = 1'b1;

    localparam logic [1:0] DIR_RIGHT = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_UP    = 2'd3;

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(4);

    typedef logic [DATA_W-1:0] data_t;

    // zero reads as one, oversize saturates
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        begin
            if (v == '0)
            begin
                r = DIM_W'(1);
            end
            else if (v > maxv)
            begin
                r = maxv;
            end
            else
            begin
                r = v;
            end
            return r;
        end
    endfunction

endpackage

[rtl/core/spiral_matrix_reorder_unit.sv]
// Loading: one element per cycle; s_tready stays high until the completing element.
// Emission: after the completing transfer each result passes the store read register
//   and the output register; one result per cycle while m_tready holds, from the single read port of the element store.
// Loading and emission of a run do not overlap: s_tready stays low while results are issued.
// Reset (rst_n, async, active low): control cleared, sizes 4x4; store contents stay
//   undefined until written, no clearing pass.
module spiral_matrix_reorder_unit
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [spmr_pkg::DATA_W-1:0] s_tdata,   // [31:0] element_value
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [spmr_pkg::DATA_W-1:0] m_tdata,   // [31:0] out_value
    output logic                        m_tlast,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [spmr_pkg::DIM_W-1:0]  cfg_data
);

    localparam logic ST_LOAD = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    localparam int PW = spmr_pkg::POS_W;
    localparam int DW = spmr_pkg::DIM_W;
    localparam int CW = spmr_pkg::CNT_W;
    localparam int AW = spmr_pkg::ADDR_W;

    spmr_pkg::data_t mem [spmr_pkg::STORE_DEPTH];

    logic          state_reg, state_next;
    logic [DW-1:0] row_count_reg, row_count_next;
    logic [DW-1:0] column_count_reg, column_count_next;
    logic [CW-1:0] load_cnt_reg, load_cnt_next;
    logic [CW-1:0] emit_cnt_reg, emit_cnt_next;
    logic [PW-1:0] row_reg, row_next;
    logic [PW-1:0] col_reg, col_next;
    logic [PW-1:0] top_reg, top_next;
    logic [PW-1:0] bottom_reg, bottom_next;
    logic [PW-1:0] left_reg, left_next;
    logic [PW-1:0] right_reg, right_next;
    logic [1:0]    dir_reg, dir_next;
    logic          rd_pend_reg, rd_pend_next;
    logic          rd_last_reg, rd_last_next;
    logic          out_valid_reg, out_valid_next;
    logic          out_last_reg, out_last_next;
    logic          skid_valid_reg, skid_valid_next;
    logic          skid_last_reg, skid_last_next;

    spmr_pkg::data_t rd_data_reg;
    spmr_pkg::data_t out_data_reg, out_data_next;
    spmr_pkg::data_t skid_data_reg, skid_data_next;

    logic [DW-1:0]   rows;
    logic [DW-1:0]   cols;
    logic [CW-1:0]   total;
    logic [CW-1:0]   load_inc;
    logic [2*DW-1:0] addr_full;
    logic [AW-1:0]   rd_addr;
    logic [1:0]      occ;
    logic            in_xfer;
    logic            pop;
    logic            issue;
    logic            is_last;

    assign rows  = spmr_pkg::clamp_dim(row_count_reg, DW'(spmr_pkg::MAX_ROWS));
    assign cols  = spmr_pkg::clamp_dim(column_count_reg, DW'(spmr_pkg::MAX_COLS));
    assign total = CW'(rows) * CW'(cols);

    assign s_tready = (state_reg == ST_LOAD);
    assign in_xfer  = s_tvalid && s_tready;
    assign load_inc = load_cnt_reg + CW'(1);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign pop      = out_valid_reg && m_tready;

    assign occ   = {1'b0, out_valid_reg} + {1'b0, skid_valid_reg} + {1'b0, rd_pend_reg};
    assign issue = (state_reg == ST_EMIT) && ((occ < 2'd2) || pop);

    assign addr_full = (2*DW)'(row_reg) * (2*DW)'(cols) + (2*DW)'(col_reg);
    assign rd_addr   = addr_full[AW-1:0];
    assign is_last   = (emit_cnt_reg == total - CW'(1));

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            mem[load_cnt_reg[AW-1:0]] <= s_tdata;
        end
        if (issue)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        row_count_next    = row_count_reg;
        column_count_next = column_count_reg;
        load_cnt_next     = load_cnt_reg;
        emit_cnt_next     = emit_cnt_reg;
        row_next          = row_reg;
        col_next          = col_reg;
        top_next          = top_reg;
        bottom_next       = bottom_reg;
        left_next         = left_reg;
        right_next        = right_reg;
        dir_next          = dir_reg;
        rd_pend_next      = issue;
        rd_last_next      = issue && is_last;

        if (cfg_we)
        begin
            if (cfg_index == spmr_pkg::REG_ROW_COUNT)
            begin
                row_count_next = cfg_data;
            end
            else
            begin
                column_count_next = cfg_data;
            end
        end

        if (in_xfer)
        begin
            if (load_inc >= total)
            begin
                load_cnt_next = '0;
                emit_cnt_next = '0;
                row_next      = '0;
                col_next      = '0;
                top_next      = '0;
                bottom_next   = PW'(rows - DW'(1));
                left_next     = '0;
                right_next    = PW'(cols - DW'(1));
                dir_next      = spmr_pkg::DIR_RIGHT;
                state_next    = ST_EMIT;
            end
            else
            begin
                load_cnt_next = load_inc;
            end
        end

        if (issue)
        begin
            emit_cnt_next = emit_cnt_reg + CW'(1);
            if (is_last)
            begin
                state_next = ST_LOAD;
            end
            case (dir_reg)
                spmr_pkg::DIR_RIGHT:
                begin
                    if (col_reg == right_reg)
                    begin
                        top_next = top_reg + PW'(1);
                        row_next = row_reg + PW'(1);
                        dir_next = spmr_pkg::DIR_DOWN;
                    end
                    else
                    begin
                        col_next = col_reg + PW'(1);
                    end
                end
                spmr_pkg::DIR_DOWN:
                begin
                    if (row_reg == bottom_reg)
                    begin
                        right_next = right_reg - PW'(1);
                        col_next   = col_reg - PW'(1);
                        dir_next   = spmr_pkg::DIR_LEFT;
                    end
                    else
                    begin
                        row_next = row_reg + PW'(1);
                    end
                end
                spmr_pkg::DIR_LEFT:
                begin
                    if (col_reg == left_reg)
                    begin
                        bottom_next = bottom_reg - PW'(1);
                        row_next    = row_reg - PW'(1);
                        dir_next    = spmr_pkg::DIR_UP;
                    end
                    else
                    begin
                        col_next = col_reg - PW'(1);
                    end
                end
                default:
                begin
                    if (row_reg == top_reg)
                    begin
                        left_next = left_reg + PW'(1);
                        col_next  = col_reg + PW'(1);
                        dir_next  = spmr_pkg::DIR_RIGHT;
                    end
                    else
                    begin
                        row_next = row_reg - PW'(1);
                    end
                end
            endcase
        end
    end

    // output register with one skid entry; read data lands in whichever is free
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_last_next   = out_last_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_last_next  = skid_last_reg;
        skid_data_next  = skid_data_reg;

        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_last_next   = skid_last_reg;
                out_data_next   = skid_data_reg;
                skid_valid_next = rd_pend_reg;
                skid_last_next  = rd_last_reg;
                skid_data_next  = rd_data_reg;
            end
            else
            begin
                out_valid_next = rd_pend_reg;
                out_last_next  = rd_last_reg;
                out_data_next  = rd_data_reg;
            end
        end
        else if (rd_pend_reg)
        begin
            skid_valid_next = 1'b1;
            skid_last_next  = rd_last_reg;
            skid_data_next  = rd_data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_LOAD;
            row_count_reg    <= spmr_pkg::DIM_RESET;
            column_count_reg <= spmr_pkg::DIM_RESET;
            load_cnt_reg     <= '0;
            emit_cnt_reg     <= '0;
            row_reg          <= '0;
            col_reg          <= '0;
            top_reg          <= '0;
            bottom_reg       <= '0;
            left_reg         <= '0;
            right_reg        <= '0;
            dir_reg          <= spmr_pkg::DIR_RIGHT;
            rd_pend_reg      <= 1'b0;
            rd_last_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_last_reg     <= 1'b0;
            skid_valid_reg   <= 1'b0;
            skid_last_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            row_count_reg    <= row_count_next;
            column_count_reg <= column_count_next;
            load_cnt_reg     <= load_cnt_next;
            emit_cnt_reg     <= emit_cnt_next;
            row_reg          <= row_next;
            col_reg          <= col_next;
            top_reg          <= top_next;
            bottom_reg       <= bottom_next;
            left_reg         <= left_next;
            right_reg        <= right_next;
            dir_reg          <= dir_next;
            rd_pend_reg      <= rd_pend_next;
            rd_last_reg      <= rd_last_next;
            out_valid_reg    <= out_valid_next;
            out_last_reg     <= out_last_next;
            skid_valid_reg   <= skid_valid_next;
            skid_last_reg    <= skid_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

[rtl/core/spmr_checker.sv]
module spmr_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [spmr_pkg::DATA_W-1:0] m_tdata,
    input logic                        m_tlast
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // input closes only after the completing transfer
    a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(s_tvalid && s_tready))
        else $error("s_tready fell without an input transfer");

    // emission is never empty: a closed input means results are on the way
    a_emit_progress: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) && !m_tvalid |=> ##1 m_tvalid)
        else $error("no result after run completed");

endmodule

bind spiral_matrix_reorder_unit spmr_checker u_spmr_checker (.*);

[dv/spiral_matrix_reorder_unit_tb.sv]
module spiral_matrix_reorder_unit_tb;

    import spmr_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int LONG_HOLD    = 200;
    localparam int SETTLE       = 12;
    localparam int TOTAL_ITEMS  = 260;

    typedef struct {
        logic [DATA_W-1:0] out_value;
        logic              run_last;
    } spiral_item_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;
    logic              m_tlast;
    logic              cfg_we = 1'b0;
    logic              cfg_index = REG_ROW_COUNT;
    logic [DIM_W-1:0]  cfg_data = '0;

    // predictor state
    logic [DATA_W-1:0] matrix_store [STORE_DEPTH];
    int                load_count = 0;
    logic [DIM_W-1:0]  row_reg = DIM_RESET;
    logic [DIM_W-1:0]  col_reg = DIM_RESET;

    spiral_item_t      expected_spiral [$];
    logic [DATA_W-1:0] pending_elements [$];

    int   fail_count = 0;
    int   idle_cycles = 0;
    logic s_accepted = 1'b0;
    int   hold_requests = 0;
    int   holds_served = 0;
    int   sent_items = 0;

    spiral_matrix_reorder_unit dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic int dim_of(input logic [DIM_W-1:0] v, input int maxv);
        int d;
        d = int'(v);
        if (d == 0)
        begin
            d = 1;
        end
        else if (d > maxv)
        begin
            d = maxv;
        end
        return d;
    endfunction

    task automatic push_cell(input int r, input int c, input int cols);
        spiral_item_t item;
        item.out_value = matrix_store[r * cols + c];
        item.run_last  = 1'b0;
        expected_spiral.insert(expected_spiral.size(), item);
    endtask

    task automatic predict_spiral(input logic [DATA_W-1:0] value);
        int         rows;
        int         cols;
        int         lo_row;
        int         hi_row;
        int         lo_col;
        int         hi_col;
        int         k;
        logic [1:0] dir;
        rows = dim_of(row_reg, MAX_ROWS);
        cols = dim_of(col_reg, MAX_COLS);
        matrix_store[load_count] = value;
        load_count++;
        if (load_count >= rows * cols)
        begin
            load_count = 0;
            lo_row = 0;
            hi_row = rows - 1;
            lo_col = 0;
            hi_col = cols - 1;
            dir = DIR_RIGHT;
            while (lo_row <= hi_row && lo_col <= hi_col)
            begin
                case (dir)
                    DIR_RIGHT:
                    begin
                        for (k = lo_col; k <= hi_col; k++)
                            push_cell(lo_row, k, cols);
                        lo_row++;
                    end
                    DIR_DOWN:
                    begin
                        for (k = lo_row; k <= hi_row; k++)
                            push_cell(k, hi_col, cols);
                        hi_col--;
                    end
                    DIR_LEFT:
                    begin
                        for (k = hi_col; k >= lo_col; k--)
                            push_cell(hi_row, k, cols);
                        hi_row--;
                    end
                    default:
                    begin
                        for (k = hi_row; k >= lo_row; k--)
                            push_cell(k, lo_col, cols);
                        lo_col++;
                    end
                endcase
                dir = dir + 2'd1;
            end
            expected_spiral[expected_spiral.size() - 1].run_last = 1'b1;
        end
    endtask

    // monitor, predictor hook and watchdog
    always @(posedge clk)
    begin
        spiral_item_t exp_item;
        logic         out_fire;
        if (rst_n)
        begin
            s_accepted = s_tvalid && s_tready;
            out_fire = m_tvalid && m_tready;
            if (s_accepted)
                predict_spiral(s_tdata);
            if (out_fire)
            begin
                if (expected_spiral.size() == 0)
                begin
                    $error("unexpected transfer: out_value %h run_last %b", m_tdata, m_tlast);
                    fail_count++;
                end
                else
                begin
                    exp_item = expected_spiral.pop_front();
                    if (m_tdata !== exp_item.out_value)
                    begin
                        $error("out_value expected %h actual %h", exp_item.out_value, m_tdata);
                        fail_count++;
                    end
                    if (m_tlast !== exp_item.run_last)
                    begin
                        $error("run_last expected %b actual %b", exp_item.run_last, m_tlast);
                        fail_count++;
                    end
                end
            end
            if (s_accepted || out_fire)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // sender: bursts with random gaps
    int burst_left = 8;
    int gap_left = 0;

    always @(negedge clk)
    begin
        logic              next_valid;
        logic [DATA_W-1:0] next_data;
        next_valid = s_tvalid;
        next_data  = s_tdata;
        if (!(s_tvalid && !s_accepted))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                next_valid = 1'b0;
            end
            else if (pending_elements.size() > 0)
            begin
                next_data  = pending_elements.pop_front();
                next_valid = 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
            begin
                next_valid = 1'b0;
            end
        end
        s_tvalid <= next_valid;
        s_tdata  <= next_data;
    end

    // receiver: stall pattern by segments, plus requested long hold-off
    int seg_left = 0;
    int seg_mode = 0;
    int hold_left = 0;

    always @(negedge clk)
    begin
        logic ready;
        if (holds_served != hold_requests)
        begin
            holds_served++;
            hold_left = LONG_HOLD;
        end
        if (seg_left == 0)
        begin
            seg_mode = $urandom_range(0, 3);
            seg_left = $urandom_range(16, 120);
        end
        else
        begin
            seg_left--;
        end
        case (seg_mode)
            0:       ready = 1'b1;
            1:       ready = 1'($urandom_range(0, 1));
            2:       ready = ($urandom_range(0, 7) != 0);
            default: ready = (seg_left % 4 == 0);
        endcase
        if (hold_left > 0)
        begin
            hold_left--;
            ready = 1'b0;
        end
        m_tready <= ready;
    end

    function automatic logic [DATA_W-1:0] rand_element();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 11))
            0:       v = 32'h8000_0000;
            1:       v = 32'h7FFF_FFFF;
            2:       v = 32'h0000_0000;
            3:       v = 32'hFFFF_FFFF;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic [DIM_W-1:0] rand_dim();
        logic [DIM_W-1:0] v;
        case ($urandom_range(0, 15))
            0:       v = '0;
            1:       v = DIM_W'($urandom_range(9, 15));
            2, 3:    v = DIM_W'(8);
            default: v = DIM_W'($urandom_range(1, 4));
        endcase
        return v;
    endfunction

    task automatic queue_element(input logic [DATA_W-1:0] v);
        pending_elements.insert(pending_elements.size(), v);
        sent_items++;
    endtask

    task automatic wait_drained();
        while (pending_elements.size() > 0 || s_tvalid || expected_spiral.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [DIM_W-1:0] val);
        wait_drained();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        if (idx == REG_ROW_COUNT)
            row_reg = val;
        else
            col_reg = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    initial
    begin
        logic [DATA_W-1:0] corner_values [16];
        int                total;
        int                runs;
        int                phase_idx;
        int                i;
        corner_values = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                          32'h0000_0001, 32'hFFFF_FFFE, 32'hAAAA_AAAA, 32'h5555_5555,
                          32'h8000_0001, 32'h7FFF_FFFE, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
                          32'h0000_FFFF, 32'hFFFF_0000, 32'h1234_5678, 32'hFEDC_BA98};
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // 4x4 out of reset, extreme values
        for (i = 0; i < 16; i++)
            queue_element(corner_values[i]);
        // zero sizes read as 1x1
        write_reg(REG_ROW_COUNT, '0);
        write_reg(REG_COLUMN_COUNT, '0);
        queue_element(32'h8000_0000);
        // oversize saturates to 8x8, then shrink below the loaded count mid-run
        write_reg(REG_ROW_COUNT, DIM_W'(15));
        write_reg(REG_COLUMN_COUNT, DIM_W'(9));
        for (i = 0; i < 3; i++)
            queue_element(rand_element());
        write_reg(REG_ROW_COUNT, DIM_W'(1));
        write_reg(REG_COLUMN_COUNT, DIM_W'(2));
        queue_element(32'h7FFF_FFFF);
        // single column
        write_reg(REG_ROW_COUNT, DIM_W'(2));
        write_reg(REG_COLUMN_COUNT, DIM_W'(1));
        queue_element(32'hFFFF_FFFF);
        queue_element(32'h0000_0000);

        phase_idx = 0;
        while (sent_items < TOTAL_ITEMS)
        begin
            phase_idx++;
            if (phase_idx == 1)
            begin
                // full matrices against a stalled receiver
                write_reg(REG_ROW_COUNT, DIM_W'(8));
                write_reg(REG_COLUMN_COUNT, DIM_W'(8));
                hold_requests++;
                for (i = 0; i < 2 * STORE_DEPTH; i++)
                    queue_element(rand_element());
            end
            else
            begin
                write_reg(REG_ROW_COUNT, rand_dim());
                write_reg(REG_COLUMN_COUNT, rand_dim());
                total = dim_of(row_reg, MAX_ROWS) * dim_of(col_reg, MAX_COLS);
                runs = $urandom_range(1, 3);
                for (i = 0; i < runs * total && sent_items < TOTAL_ITEMS; i++)
                    queue_element(rand_element());
                // leave a partial load so the next size change lands mid-run
                if (total > 1 && $urandom_range(0, 3) == 0)
                begin
                    runs = $urandom_range(1, total - 1);
                    for (i = 0; i < runs && sent_items < TOTAL_ITEMS; i++)
                        queue_element(rand_element());
                end
            end
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && expected_spiral.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
